/* hw/rtl/lcfp_pkg.sv */
`timescale 1ns / 1ps

package lcfp_pkg;

	localparam int DEF_COLOR_BITS = 7;
	localparam int DEF_TIME_BITS  = 32;
	localparam int LEN_BITS       = 16;
	localparam int FUNC_BITS      = 2;
	localparam int STEP_BITS      = 4;

	localparam logic [LEN_BITS-1:0] FRAME_STEP_RESET = 16'd20;

	localparam logic [FUNC_BITS-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_SET   = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_PULSE = 2'd2;

	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_IDLE       = 4'd0;
	localparam step_t STEP_SCREEN     = 4'd1;
	localparam step_t STEP_ROUTE      = 4'd2;
	localparam step_t STEP_BEGIN      = 4'd3;
	localparam step_t STEP_HALF       = 4'd4;
	localparam step_t STEP_END_CHECK  = 4'd5;
	localparam step_t STEP_END_WAIT   = 4'd6;
	localparam step_t STEP_FINISH     = 4'd7;
	localparam step_t STEP_FRAME_CHK  = 4'd8;
	localparam step_t STEP_FRAME      = 4'd9;
	localparam step_t STEP_DIV_LOAD   = 4'd10;
	localparam step_t STEP_DIV_STEP   = 4'd11;
	localparam step_t STEP_DIV_STORE  = 4'd12;
	localparam step_t STEP_EMIT_WAIT  = 4'd13;
	localparam step_t STEP_EMIT       = 4'd14;

	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_ACCEPT    = 4'd1,
		OP_BEGIN     = 4'd2,
		OP_HALF      = 4'd3,
		OP_FINISH    = 4'd4,
		OP_FRAME     = 4'd5,
		OP_DIV_LOAD  = 4'd6,
		OP_DIV_STEP  = 4'd7,
		OP_DIV_STORE = 4'd8,
		OP_EMIT      = 4'd9
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER     = 4'd0,
		C_ALWAYS    = 4'd1,
		C_NO_ITEM   = 4'd2,
		C_SKIP      = 4'd3,
		C_IS_TICK   = 4'd4,
		C_NOT_ENDED = 4'd5,
		C_OUT_BUSY  = 4'd6,
		C_NO_FRAME  = 4'd7,
		C_DIV_MORE  = 4'd8,
		C_CHAN_MORE = 4'd9
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	function automatic ucode_t ucode(input step_t s);
		ucode_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE};
		case (s)
			STEP_IDLE:      w = '{op: OP_ACCEPT,    cond: C_NO_ITEM,   target: STEP_IDLE};
			STEP_SCREEN:    w = '{op: OP_NONE,      cond: C_SKIP,      target: STEP_IDLE};
			STEP_ROUTE:     w = '{op: OP_NONE,      cond: C_IS_TICK,   target: STEP_HALF};
			STEP_BEGIN:     w = '{op: OP_BEGIN,     cond: C_ALWAYS,    target: STEP_IDLE};
			STEP_HALF:      w = '{op: OP_HALF,      cond: C_NEVER,     target: STEP_IDLE};
			STEP_END_CHECK: w = '{op: OP_NONE,      cond: C_NOT_ENDED, target: STEP_FRAME_CHK};
			STEP_END_WAIT:  w = '{op: OP_NONE,      cond: C_OUT_BUSY,  target: STEP_END_WAIT};
			STEP_FINISH:    w = '{op: OP_FINISH,    cond: C_ALWAYS,    target: STEP_IDLE};
			STEP_FRAME_CHK: w = '{op: OP_NONE,      cond: C_NO_FRAME,  target: STEP_IDLE};
			STEP_FRAME:     w = '{op: OP_FRAME,     cond: C_NEVER,     target: STEP_IDLE};
			STEP_DIV_LOAD:  w = '{op: OP_DIV_LOAD,  cond: C_NEVER,     target: STEP_IDLE};
			STEP_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  target: STEP_DIV_STEP};
			STEP_DIV_STORE: w = '{op: OP_DIV_STORE, cond: C_CHAN_MORE, target: STEP_DIV_LOAD};
			STEP_EMIT_WAIT: w = '{op: OP_NONE,      cond: C_OUT_BUSY,  target: STEP_EMIT_WAIT};
			STEP_EMIT:      w = '{op: OP_EMIT,      cond: C_ALWAYS,    target: STEP_IDLE};
			default:        w = '{op: OP_NONE,      cond: C_ALWAYS,    target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/lcfp_if.sv */
`timescale 1ns / 1ps

interface lcfp_cmd_if
	import lcfp_pkg::*;
#(
	parameter int COLOR_BITS = DEF_COLOR_BITS,
	parameter int TIME_BITS  = DEF_TIME_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [FUNC_BITS-1:0]  func;
	logic [TIME_BITS-1:0]  now;
	logic [LEN_BITS-1:0]   duration;
	logic [COLOR_BITS-1:0] first_red;
	logic [COLOR_BITS-1:0] first_green;
	logic [COLOR_BITS-1:0] first_blue;
	logic [COLOR_BITS-1:0] second_red;
	logic [COLOR_BITS-1:0] second_green;
	logic [COLOR_BITS-1:0] second_blue;

	modport source (output valid, func, now, duration, first_red, first_green, first_blue,
		second_red, second_green, second_blue, input ready);
	modport sink (input valid, func, now, duration, first_red, first_green, first_blue,
		second_red, second_green, second_blue, output ready);
endinterface

interface lcfp_res_if
	import lcfp_pkg::*;
#(
	parameter int COLOR_BITS = DEF_COLOR_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;
	logic                  done_res;

	modport source (output valid, red, green, blue, done_res, input ready);
	modport sink (input valid, red, green, blue, done_res, output ready);
endinterface

/* hw/rtl/lcfp_div.sv */
`timescale 1ns / 1ps

module lcfp_div
	import lcfp_pkg::*;
#(
	parameter int DIVIDEND_BITS = DEF_COLOR_BITS + LEN_BITS,
	parameter int DIVISOR_BITS  = LEN_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  div_ctrl_t                ctrl,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic [DIVIDEND_BITS-1:0] quotient,
	output logic                     last
);
	localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     fits;

	assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (ctrl.step) begin
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
		end
	end

	assign quotient = quo_q;
	assign last     = cnt_q == CNT_BITS'(DIVIDEND_BITS - 1);
endmodule

/* hw/rtl/led_color_fade_pulse.sv */
`timescale 1ns / 1ps
// Whole-strip color fader: linear crossfade to a target color, or endless
// pulsing between two colors.
// Channels: cmd (valid/ready beat carrying func, now, duration and two colors),
// res (valid/ready beat carrying red, green, blue, done_res), and a frame_step
// write port (cfg_we, cfg_data), which the user writes only while the block is
// idle; the block itself has no check for this. Each cmd beat is taken in the
// idle step of a microcoded sequencer. Set and pulse commands give no result;
// a tick while idle and an unknown func are skipped. A tick returns to idle
// when nothing is due, emits a done result when the fade ends, and computes a
// frame when one is due: each color channel runs a restoring divider one
// quotient bit per cycle.
// The result sits in an output register; the next cmd beat is taken while it
// waits. When a tick needs to emit and res still holds an untaken beat, the
// sequencer holds in a wait step until the receiver takes it.
// Reset clears the fade colors, times and flags, sets frame_step to 20 and drops
// res.valid; the block takes cmd beats on the first cycle after reset.
module led_color_fade_pulse
	import lcfp_pkg::*;
#(
	parameter int COLOR_BITS = DEF_COLOR_BITS,
	parameter int TIME_BITS  = DEF_TIME_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	lcfp_cmd_if.sink            cmd,
	lcfp_res_if.source          res,
	input  logic                cfg_we,
	input  logic [LEN_BITS-1:0] cfg_data
);
	localparam int DIV_BITS = COLOR_BITS + LEN_BITS;

	typedef logic [COLOR_BITS-1:0] color_t;

	step_t                step_q;
	step_t                step_d;
	ucode_t               uw;
	logic                 take;

	logic [LEN_BITS-1:0]  frame_step_q;
	logic [FUNC_BITS-1:0] func_q;
	logic [TIME_BITS-1:0] now_q;
	logic [LEN_BITS-1:0]  dur_q;
	color_t               first_q [3];
	color_t               second_q [3];

	color_t               shown_q [3];
	color_t               start_q [3];
	color_t               target_q [3];
	color_t               alt_q [3];
	logic [TIME_BITS-1:0] start_time_q;
	logic [TIME_BITS-1:0] end_time_q;
	logic [TIME_BITS-1:0] next_frame_q;
	logic [LEN_BITS-1:0]  len_q;
	logic                 anim_q;
	logic                 pulse_q;

	logic [TIME_BITS-1:0] elapsed_q;
	logic [1:0]           chan_q;

	logic                 out_valid_q;
	color_t               out_red_q;
	color_t               out_green_q;
	color_t               out_blue_q;
	logic                 out_done_q;

	logic                 out_busy;
	logic                 ended;
	logic                 frame_due;
	logic                 skip;
	logic                 full;
	logic                 up;
	color_t               cur_s;
	color_t               cur_t;
	color_t               mag;
	color_t               quo;
	color_t               blended;

	div_ctrl_t            div_ctrl;
	logic [DIV_BITS-1:0]  div_quo;
	logic                 div_last;
	logic [DIV_BITS-1:0]  product;

	assign uw        = ucode(step_q);
	assign out_busy  = out_valid_q && !res.ready;
	assign ended     = now_q >= end_time_q;
	assign frame_due = now_q > next_frame_q;
	assign skip      = !(func_q == FUNC_SET || func_q == FUNC_PULSE ||
		(func_q == FUNC_TICK && anim_q));
	assign full      = (len_q == '0) || (elapsed_q >= TIME_BITS'(len_q));

	assign cur_s   = start_q[chan_q];
	assign cur_t   = target_q[chan_q];
	assign up      = cur_t >= cur_s;
	assign mag     = up ? cur_t - cur_s : cur_s - cur_t;
	assign product = DIV_BITS'(mag) * DIV_BITS'(elapsed_q[LEN_BITS-1:0]);
	assign quo     = div_quo[COLOR_BITS-1:0];
	assign blended = full ? cur_t : (up ? cur_s + quo : cur_s - quo);

	assign div_ctrl.load = uw.op == OP_DIV_LOAD;
	assign div_ctrl.step = uw.op == OP_DIV_STEP;

	lcfp_div #(
		.DIVIDEND_BITS(DIV_BITS),
		.DIVISOR_BITS (LEN_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (div_ctrl),
		.dividend(product),
		.divisor (len_q),
		.quotient(div_quo),
		.last    (div_last)
	);

	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ITEM:   take = !cmd.valid;
			C_SKIP:      take = skip;
			C_IS_TICK:   take = func_q == FUNC_TICK;
			C_NOT_ENDED: take = !ended;
			C_OUT_BUSY:  take = out_busy;
			C_NO_FRAME:  take = !frame_due;
			C_DIV_MORE:  take = !div_last;
			C_CHAN_MORE: take = chan_q != 2'd2;
			default:     take = 1'b1;
		endcase
		step_d = take ? uw.target : step_t'(step_q + 1'b1);
	end

	assign cmd.ready = uw.op == OP_ACCEPT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_step_q <= FRAME_STEP_RESET;
		end else if (cfg_we) begin
			frame_step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_ACCEPT && cmd.valid) begin
			func_q      <= cmd.func;
			now_q       <= cmd.now;
			dur_q       <= cmd.duration;
			first_q[0]  <= cmd.first_red;
			first_q[1]  <= cmd.first_green;
			first_q[2]  <= cmd.first_blue;
			second_q[0] <= cmd.second_red;
			second_q[1] <= cmd.second_green;
			second_q[2] <= cmd.second_blue;
		end
		if (uw.op == OP_FRAME) begin
			elapsed_q <= now_q - start_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				shown_q[c]  <= '0;
				start_q[c]  <= '0;
				target_q[c] <= '0;
				alt_q[c]    <= '0;
			end
			start_time_q <= '0;
			end_time_q   <= '0;
			next_frame_q <= '0;
			len_q        <= '0;
			anim_q       <= 1'b0;
			pulse_q      <= 1'b0;
			chan_q       <= '0;
		end else begin
			case (uw.op)
				OP_BEGIN: begin
					for (int c = 0; c < 3; c++) begin
						start_q[c]  <= shown_q[c];
						target_q[c] <= first_q[c];
						if (func_q == FUNC_PULSE) begin
							alt_q[c] <= second_q[c];
						end
					end
					start_time_q <= now_q;
					len_q        <= dur_q;
					next_frame_q <= now_q + TIME_BITS'(frame_step_q);
					end_time_q   <= now_q + TIME_BITS'(dur_q);
					anim_q       <= 1'b1;
					pulse_q      <= func_q == FUNC_PULSE;
				end
				OP_HALF: begin
					if (pulse_q && ended) begin
						start_time_q <= end_time_q;
						end_time_q   <= end_time_q + TIME_BITS'(len_q);
						for (int c = 0; c < 3; c++) begin
							start_q[c]  <= target_q[c];
							target_q[c] <= alt_q[c];
							alt_q[c]    <= target_q[c];
						end
					end
				end
				OP_FINISH: begin
					anim_q <= 1'b0;
					for (int c = 0; c < 3; c++) begin
						shown_q[c] <= target_q[c];
					end
				end
				OP_FRAME: begin
					next_frame_q <= next_frame_q + TIME_BITS'(frame_step_q);
					chan_q       <= '0;
				end
				OP_DIV_STORE: begin
					shown_q[chan_q] <= blended;
					chan_q          <= chan_q + 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_FINISH || uw.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_FINISH) begin
			out_red_q   <= target_q[0];
			out_green_q <= target_q[1];
			out_blue_q  <= target_q[2];
			out_done_q  <= 1'b1;
		end else if (uw.op == OP_EMIT) begin
			out_red_q   <= shown_q[0];
			out_green_q <= shown_q[1];
			out_blue_q  <= shown_q[2];
			out_done_q  <= 1'b0;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.red      = out_red_q;
	assign res.green    = out_green_q;
	assign res.blue     = out_blue_q;
	assign res.done_res = out_done_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_FINISH || uw.op == OP_EMIT) |-> !out_busy)
		else $error("result register loaded while a beat is still pending");

	a_finish_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_FINISH) |=> (!anim_q && res.valid && res.done_res))
		else $error("finished fade did not stop the animation or emit done");

	a_stop_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(anim_q) |-> $past(uw.op == OP_FINISH))
		else $error("animation stopped outside the finish step");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DIV_STORE && !full) |-> (div_quo[DIV_BITS-1:COLOR_BITS] == '0))
		else $error("blend quotient exceeds the color range");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DIV_LOAD) |-> (chan_q != 2'd3))
		else $error("channel index out of range");
endmodule
